/* hw/rtl/msm_pkg.sv */
`default_nettype none

package msm_pkg;

  localparam int unsigned MaxEntriesDefault = 512;
  localparam int unsigned LogitWidthDefault = 16;

  localparam int unsigned TempWidth = 16;
  localparam int unsigned ProbWidth = 16;
  localparam int unsigned ExpWidth  = 16;

  localparam logic [TempWidth-1:0] InvTempReset = 16'd4096;
  // log2(e) in Q1.15
  localparam logic [15:0]          Log2eQ15     = 16'd47274;
  localparam logic [ExpWidth-1:0]  ExpOne       = 16'd32768;
  localparam logic [ProbWidth-1:0] ProbMax      = 16'hFFFF;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRead = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/masked_policy_softmax.sv */
`default_nettype none

// Load: each element is stored and its scaled logit compared with the max; the last load adds
// a sum pass over every stored element (memory read, scale, log2 multiply, exp and accumulate).
// Read: the strobe follows the read, scale, log2 multiply and exp steps and, unless the entry
// is illegal or saturated, the 16-step divider; the next command is taken in the strobe cycle.
// The result shows for one cycle on result_valid_o; the receiver cannot stall.
// Reset clears control state and sets inv_temperature to 1.0; the memory is not cleared.
module masked_policy_softmax #(
  parameter int unsigned MAX_ENTRIES = msm_pkg::MaxEntriesDefault,
  parameter int unsigned LOGIT_WIDTH = msm_pkg::LogitWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          cmd_i,
  input  wire logic signed [LOGIT_WIDTH-1:0] logit_i,
  input  wire logic                          legal_i,
  input  wire logic                          load_last_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [msm_pkg::TempWidth-1:0] cfg_data_i,
  output logic                               result_valid_o,
  output logic [msm_pkg::ProbWidth-1:0]      prob_o,
  output logic                               illegal_o,
  output logic                               no_legal_o,
  output logic                               read_last_o
);
  import msm_pkg::*;

  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW   = LOGIT_WIDTH + TempWidth + 1;
  localparam int unsigned TW   = SW - 6;
  localparam int unsigned YW   = TW + 17;
  localparam int unsigned SUMW = CW + 16;
  localparam int unsigned MW   = LOGIT_WIDTH + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LMAX, S_RD, S_MUL, S_LOG, S_EXP, S_DIV, S_OUT
  } state_e;

  typedef enum logic {PH_LOADING, PH_READING} phase_e;

  state_e                   state_q;
  phase_e                   phase_q;
  logic [TempWidth-1:0]     temp_q;
  logic signed [SW-1:0]     max_q;
  logic signed [SW-1:0]     prod_q;
  logic [SUMW-1:0]          sum_q;
  logic [CW-1:0]            lcnt_q;
  logic [CW-1:0]            ecnt_q;
  logic [CW-1:0]            idx_q;
  logic                     ld_leg_q;
  logic                     last_q;
  logic                     sum_mode_q;
  logic                     leg_q;
  logic [YW-1:0]            ymul_q;
  logic [SUMW:0]            rem_q;
  logic [SUMW-1:0]          den_q;
  logic [ProbWidth-1:0]     quot_q;
  logic [3:0]               dcnt_q;
  logic                     valid_q;
  logic [ProbWidth-1:0]     prob_q;
  logic                     ill_q;
  logic                     nol_q;
  logic                     rl_q;

  logic [MW-1:0]            mem [MAX_ENTRIES];
  logic [MW-1:0]            rdata_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [MW-1:0]            mem_wdata;

  logic                     load_go;
  logic [CW-1:0]            ecnt_base;
  logic [CW-1:0]            lcnt_base;
  logic                     room;
  logic signed [SW-1:0]     load_prod;
  logic signed [SW-1:0]     rd_prod;
  logic [SW-1:0]            xdiff;
  logic [TW-1:0]            tval;
  logic [3:0]               nsh;
  logic [15:0]              frac;
  logic [ExpWidth-1:0]      expv;
  logic [SUMW-1:0]          num;
  logic [SUMW-1:0]          den;
  logic [SUMW:0]            rem2;
  logic [CW-1:0]            idx_inc;

  assign load_go   = (state_q == S_IDLE) && start_i && (cmd_i == CmdLoad);
  assign ecnt_base = (phase_q == PH_READING) ? '0 : ecnt_q;
  assign lcnt_base = (phase_q == PH_READING) ? '0 : lcnt_q;
  assign room      = (ecnt_base < CW'(MAX_ENTRIES));
  assign mem_we    = load_go && room;
  assign mem_waddr = ecnt_base[AW-1:0];
  assign mem_wdata = {legal_i, logit_i};

  assign load_prod = SW'(logit_i) * $signed({1'b0, temp_q});
  assign rd_prod   = SW'($signed(rdata_q[LOGIT_WIDTH-1:0])) * $signed({1'b0, temp_q});

  assign xdiff = (prod_q >= max_q) ? '0 : SW'(max_q - prod_q);
  assign tval  = xdiff[SW-1:6];

  // y = ymul >> 15, n = y >> 16, f = y[15:0]
  assign nsh  = ymul_q[34:31];
  assign frac = ymul_q[30:15];
  always_comb begin
    if (ymul_q[YW-1:35] != '0) begin
      expv = '0;
    end else begin
      expv = (ExpOne - {2'b00, frac[15:2]}) >> nsh;
    end
  end

  // zero-sum fallback divides 1.0 by the legal count
  assign num  = (sum_q != '0) ? SUMW'(expv) : SUMW'(1);
  assign den  = (sum_q != '0) ? sum_q : SUMW'(lcnt_q);
  assign rem2 = {rem_q[SUMW-1:0], 1'b0};
  assign idx_inc = idx_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_LOADING;
      temp_q     <= InvTempReset;
      max_q      <= {1'b1, {(SW-1){1'b0}}};
      prod_q     <= '0;
      sum_q      <= '0;
      lcnt_q     <= '0;
      ecnt_q     <= '0;
      idx_q      <= '0;
      ld_leg_q   <= 1'b0;
      last_q     <= 1'b0;
      sum_mode_q <= 1'b0;
      leg_q      <= 1'b0;
      ymul_q     <= '0;
      rem_q      <= '0;
      den_q      <= '0;
      quot_q     <= '0;
      dcnt_q     <= '0;
      valid_q    <= 1'b0;
      prob_q     <= '0;
      ill_q      <= 1'b0;
      nol_q      <= 1'b0;
      rl_q       <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        temp_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load_go) begin
            phase_q  <= PH_LOADING;
            prod_q   <= load_prod;
            ld_leg_q <= legal_i && room;
            last_q   <= load_last_i;
            ecnt_q   <= room ? ecnt_base + CW'(1) : ecnt_base;
            lcnt_q   <= (room && legal_i) ? lcnt_base + CW'(1) : lcnt_base;
            if (phase_q == PH_READING) begin
              max_q <= {1'b1, {(SW-1){1'b0}}};
            end
            state_q  <= S_LMAX;
          end else if (start_i && phase_q == PH_READING) begin
            sum_mode_q <= 1'b0;
            state_q    <= S_RD;
          end
        end
        S_LMAX: begin
          if (ld_leg_q && prod_q > max_q) begin
            max_q <= prod_q;
          end
          if (last_q) begin
            idx_q      <= '0;
            sum_q      <= '0;
            sum_mode_q <= 1'b1;
            state_q    <= S_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= rd_prod;
          leg_q   <= rdata_q[LOGIT_WIDTH];
          state_q <= S_LOG;
        end
        S_LOG: begin
          ymul_q  <= YW'(tval) * YW'(Log2eQ15);
          state_q <= S_EXP;
        end
        S_EXP: begin
          if (sum_mode_q) begin
            if (leg_q) begin
              sum_q <= sum_q + SUMW'(expv);
            end
            if (idx_inc == ecnt_q) begin
              idx_q   <= '0;
              phase_q <= PH_READING;
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_inc;
              state_q <= S_RD;
            end
          end else begin
            den_q  <= den;
            dcnt_q <= '0;
            rem_q  <= {1'b0, num};
            if (!leg_q) begin
              quot_q  <= '0;
              state_q <= S_OUT;
            end else if (num >= den) begin
              quot_q  <= ProbMax;
              state_q <= S_OUT;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem2 >= {1'b0, den_q}) begin
            rem_q  <= rem2 - {1'b0, den_q};
            quot_q <= {quot_q[ProbWidth-2:0], 1'b1};
          end else begin
            rem_q  <= rem2;
            quot_q <= {quot_q[ProbWidth-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 4'd1;
          if (dcnt_q == 4'd15) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          valid_q <= 1'b1;
          prob_q  <= quot_q;
          ill_q   <= !leg_q;
          nol_q   <= (lcnt_q == '0);
          rl_q    <= (idx_inc == ecnt_q);
          if (idx_inc == ecnt_q) begin
            // vector done: drop back to loading
            idx_q   <= '0;
            ecnt_q  <= '0;
            lcnt_q  <= '0;
            sum_q   <= '0;
            max_q   <= {1'b1, {(SW-1){1'b0}}};
            phase_q <= PH_LOADING;
          end else begin
            idx_q <= idx_inc;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  // take the register only while no command is in flight or arriving
  assign cfg_ready_o    = (state_q == S_IDLE) && !start_i;
  assign result_valid_o = valid_q;
  assign prob_o         = prob_q;
  assign illegal_o      = ill_q;
  assign no_legal_o     = nol_q;
  assign read_last_o    = rl_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");
  a_legal_le_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q <= ecnt_q)
    else $error("legal count exceeds entry count");
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q) == S_OUT)
    else $error("result strobe without output step");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rl_q) |-> (phase_q == PH_LOADING && ecnt_q == '0))
    else $error("vector not cleared after final read");
`endif

endmodule

`default_nettype wire
